// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  // item field widths
  localparam int CHAR_W     = 8;
  localparam int FG_W       = 4;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int CELL_W     = 16;
  localparam int CROW_W     = 5;
  localparam int CCOL_W     = 7;
  localparam int HWP_W      = 11;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 40;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } tcw_op_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // capture the incoming item
    logic offset;       // register row*WIDTH+col
    logic addr;         // register rotated store address
    logic access;       // store read/write, cursor update
    logic scroll_load;  // arm the row clear at the recycled row
    logic scroll;       // clear one cell of the recycled row
    logic clear;        // clear one cell after reset
    logic finish;       // load the result register
  } tcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_read;
    logic scroll_due;
    logic clear_done;
    logic row_done;
    logic out_free;
  } tcw_status_t;

endpackage

// ===== hdl/tcw_ctrl.sv =====
`timescale 1ns / 1ps

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  tcw_status_t status,
  output tcw_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_OFFSET = 7'b0000100,
    S_ADDR   = 7'b0001000,
    S_ACCESS = 7'b0010000,
    S_SCROLL = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_OFFSET;
        end
      end
      S_OFFSET: begin
        cmd.offset = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_ACCESS;
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        if (!status.op_read && status.scroll_due) begin
          cmd.scroll_load = 1'b1;
          state_next      = S_SCROLL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCROLL: begin
        cmd.scroll = 1'b1;
        if (status.row_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/tcw_datapath.sv =====
`timescale 1ns / 1ps

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int WIDTH  = 80,
  parameter int HEIGHT = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcw_cmd_t             cmd,
  output tcw_status_t          status,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser
);

  localparam int CELLS = WIDTH * HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(WIDTH);
  localparam int RW    = $clog2(HEIGHT);

  // captured item
  tcw_op_t             op_q;
  logic [CHAR_W-1:0]   ch_q;
  logic [FG_W-1:0]     fg_q;
  logic [RROW_W-1:0]   rrow_q;
  logic [RCOL_W-1:0]   rcol_q;
  logic                rd_ok;

  // cursor and ring base
  logic [RW-1:0]       row;
  logic [CW-1:0]       col;
  logic [HWP_W-1:0]    hw_cursor;
  logic [AW-1:0]       top_base;

  logic [AW-1:0]       sweep_addr;
  logic [CW-1:0]       sweep_cnt;
  logic [AW-1:0]       off;
  logic [AW-1:0]       addr;
  logic [CELL_W-1:0]   rdata;
  logic [CELL_W-1:0]   mem [CELLS];

  logic                is_nl;
  logic                is_put;
  logic                last_col;
  logic                last_row;
  logic [RW-1:0]       sel_row;
  logic [CW-1:0]       sel_col;
  logic [AW:0]         addr_sum;
  logic [AW-1:0]       addr_next;
  logic [AW:0]         tb_sum;
  logic [AW-1:0]       top_base_next;
  logic                sweeping;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   wdata;
  logic [HWP_W-1:0]    hw_new;
  logic [CELL_W-1:0]   cell_out;
  logic                rd_ok_in;

  assign is_nl    = (ch_q == NEWLINE_CODE);
  assign is_put   = (op_q == OP_PUT);
  assign last_col = (col == CW'(WIDTH - 1));
  assign last_row = (row == RW'(HEIGHT - 1));

  assign status.op_read    = (op_q == OP_READ);
  assign status.scroll_due = last_row && (is_nl || last_col);
  assign status.clear_done = (sweep_addr == AW'(CELLS - 1));
  assign status.row_done   = (sweep_cnt == CW'(WIDTH - 1));
  assign status.out_free   = !m_tvalid || m_tready;

  assign rd_ok_in = (32'(s_tdata[CHAR_W+FG_W +: RROW_W]) < HEIGHT) &&
                    (32'(s_tdata[CHAR_W+FG_W+RROW_W +: RCOL_W]) < WIDTH);

  // logical position -> offset within the visible window
  assign sel_row = status.op_read ? RW'(rrow_q) : row;
  assign sel_col = status.op_read ? CW'(rcol_q) : col;

  // rotate by the ring base, one conditional subtract
  assign addr_sum  = {1'b0, top_base} + {1'b0, off};
  assign addr_next = (addr_sum >= (AW+1)'(CELLS)) ? AW'(addr_sum - (AW+1)'(CELLS))
                                                   : AW'(addr_sum);

  assign tb_sum        = {1'b0, top_base} + (AW+1)'(WIDTH);
  assign top_base_next = (tb_sum >= (AW+1)'(CELLS)) ? '0 : AW'(tb_sum);

  assign sweeping = cmd.clear || cmd.scroll;
  assign we       = sweeping || (cmd.access && is_put && !is_nl);
  assign waddr    = sweeping ? sweep_addr : addr;
  assign wdata    = sweeping ? '0 : {{(CELL_W-CHAR_W-FG_W){1'b0}}, fg_q, ch_q};

  assign hw_new   = HWP_W'(32'(row) * 32'(WIDTH));
  assign cell_out = (status.op_read && rd_ok) ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= tcw_op_t'(s_tuser);
      ch_q   <= s_tdata[0 +: CHAR_W];
      fg_q   <= s_tdata[CHAR_W +: FG_W];
      rrow_q <= s_tdata[CHAR_W+FG_W +: RROW_W];
      rcol_q <= s_tdata[CHAR_W+FG_W+RROW_W +: RCOL_W];
      rd_ok  <= rd_ok_in;
    end
    if (cmd.offset) begin
      off <= AW'(sel_row) * AW'(WIDTH) + AW'(sel_col);
    end
    if (cmd.addr) begin
      addr <= addr_next;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.access && status.op_read && rd_ok) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      hw_cursor  <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      sweep_cnt  <= '0;
    end else begin
      if (cmd.access && is_put) begin
        if (is_nl || last_col) begin
          col <= '0;
          if (!last_row) begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cmd.scroll_load) begin
        sweep_addr <= top_base;
        sweep_cnt  <= '0;
      end else if (sweeping) begin
        sweep_addr <= sweep_addr + 1'b1;
        sweep_cnt  <= sweep_cnt + 1'b1;
      end
      if (cmd.scroll && status.row_done) begin
        top_base <= top_base_next;
      end
      if (cmd.finish && is_put && is_nl) begin
        hw_cursor <= hw_new;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {1'b0,
                  (is_put && is_nl) ? hw_new : hw_cursor,
                  CCOL_W'(col),
                  CROW_W'(row),
                  cell_out};
      m_tuser <= is_put && is_nl;
    end
  end

endmodule

// ===== hdl/text_console_writer_top.sv =====
`timescale 1ns / 1ps

// Text console writer. Holds a WIDTH x HEIGHT store of 16-bit cells (char in
// the low byte, foreground colour in bits 8-11, black background) and a write
// cursor. A put item writes the cell under the cursor and advances it,
// wrapping at the row end; newline (10) goes to column 0 of the next row and
// loads the hardware cursor with row*WIDTH+col. Past the bottom row the
// screen scrolls: rows are kept as a ring in one single-port-write memory, so
// a scroll only clears the recycled row and moves the ring base. A read item
// returns one cell, or 0 outside the screen. Every item returns one result
// with the cursor after it. Sequencing: one item at a time, in the steps
// accept, offset, address rotate, store access and result, plus a row clear
// when a put or newline scrolls; the row clear runs one cell per cycle. After
// reset the block clears the whole store, one cell a cycle, before s_tready
// first rises. The result register lets the next item start while a result
// still waits on m_tready.

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int WIDTH  = 80,
  parameter int HEIGHT = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: char_code[7:0], fg_index[11:8], read_row[16:12], read_col[23:17]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: opcode (0 put, 1 read)
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: cell_value[15:0], cursor_row[20:16], cursor_col[27:21],
  //          hw_cursor_pos[38:28], zero pad[39]
  output logic [M_TDATA_W-1:0] m_tdata,
  // m_tuser: hw_cursor_loaded
  output logic                 m_tuser
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // sequencing: reset clear, per-item steps, scroll row clear
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // item capture, cursor, ring base, cell memory and result register
  tcw_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hdl/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int WIDTH  = 80,
  parameter int HEIGHT = 25
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  localparam int ROW_LSB = CELL_W;
  localparam int COL_LSB = CELL_W + CROW_W;

  // one item in flight: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // newline leaves the cursor in column 0
  a_nl_col0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[COL_LSB +: CCOL_W] == '0)
    else $error("cursor load with non-zero column");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[COL_LSB +: CCOL_W]) < WIDTH) &&
                 (32'(m_tdata[ROW_LSB +: CROW_W]) < HEIGHT))
    else $error("cursor off screen");

endmodule

bind text_console_writer_top tcw_checker #(
  .WIDTH  (WIDTH),
  .HEIGHT (HEIGHT)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
